// ----- design/bmn_pkg.sv -----
// Package for the Box-Muller normal pair generator: fixed-point constants,
// stage latencies and the constant tables of the sine series.
// No dependencies.
`timescale 1ns / 1ps
package bmn_pkg;

	// Default sizes of the top-level fields.
	localparam int DEF_UNIFORM_BITS = 24;
	localparam int DEF_OUT_FRAC_BITS = 16;

	// Fixed-point constants.
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;
	localparam logic [27:0] LN2_Q28     = 28'd186065280;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// Stage counts of the pipeline parts.
	localparam int LOG_LAT = 31;
	localparam int RAD_LAT = LOG_LAT + 2 + 32;
	localparam int SIN_LAT = 23;
	localparam int ANG_LAT = 2;
	localparam int FIN_LAT = 2;
	localparam int ALIGN_LAT = RAD_LAT - ANG_LAT - SIN_LAT;
	localparam int TOTAL_LAT = RAD_LAT + FIN_LAT;

	// Divisor of the Horner term k of the sine series: (2k)(2k+1).
	function automatic logic [7:0] horner_div(input int k);
		logic [7:0] d;
		unique case (k)
			7: d = 8'd210;
			6: d = 8'd156;
			5: d = 8'd110;
			4: d = 8'd72;
			3: d = 8'd42;
			2: d = 8'd20;
			1: d = 8'd6;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// Reciprocal of the same divisor, floor(2^33 / d).
	function automatic logic [30:0] horner_recip(input int k);
		logic [30:0] r;
		unique case (k)
			7: r = 31'd40904450;
			6: r = 31'd55063683;
			5: r = 31'd78090314;
			4: r = 31'd119304647;
			3: r = 31'd204522252;
			2: r = 31'd429496729;
			1: r = 31'd1431655765;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/box_muller_normal_pair.sv -----
// Top level of the Box-Muller normal pair generator: angle front end, sine
// lanes, radius path, alignment and output rounding. Depends on bmn_pkg,
// bmn_radius, bmn_sin and bmn_delay.
//
// Usage:
//   The slave stream takes one transaction per pair of uniform samples; the
//   master stream gives one transaction per pair of normal samples, in order.
//   The first sample sets the radius sqrt(-2 ln(1 - u)), the second the angle
//   2 pi u; the results are the radius times the cosine and the sine, with
//   OUT_FRAC_BITS fraction bits, rounded and saturated.
//   The path length is set by the logarithm (30 squaring stages) and the
//   square root (32 stages, one result bit each); the sine lanes run beside
//   them. Throughput is one transaction per cycle while the receiver takes
//   results. Every stage is a register with a valid bit; the final stage is
//   the output register.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready is low; nothing is lost or repeated. Otherwise s_tready is
//   high, also while results are in flight.
//   Reset clears all valid bits; the block is ready in the first cycle after.
`timescale 1ns / 1ps
module box_muller_normal_pair import bmn_pkg::*; #(
	parameter int UNIFORM_BITS = DEF_UNIFORM_BITS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
	localparam int OUT_W = OUT_FRAC_BITS + 4,
	localparam int IN_TW = ((2 * UNIFORM_BITS + 7) / 8) * 8,
	localparam int OUT_TW = ((2 * OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// Fields from bit 0: u_first, u_second, zero fill.
	input  logic [IN_TW-1:0]  s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// Fields from bit 0: normal_cos, normal_sin, zero fill.
	output logic [OUT_TW-1:0] m_tdata
);

	localparam int FB = UNIFORM_BITS - 2;
	localparam int SH = 58 - OUT_FRAC_BITS;
	localparam logic [63:0] HALF = 64'd1 << (OUT_W - 1);
	localparam logic [63:0] ROUND = 64'd1 << (SH - 1);

	logic                    adv;
	logic [TOTAL_LAT-1:0]    vld_q;
	logic [UNIFORM_BITS-1:0] u_first;
	logic [UNIFORM_BITS-1:0] u_second;
	logic [FB-1:0]           f;
	logic [FB+15:0]          pp_lo_s1;
	logic [FB+14:0]          pp_hi_s1;
	logic [1:0]              q_s1;
	logic [FB+30:0]          ang_sum;
	logic [30:0]             phi_s2;
	logic [30:0]             cphi_s2;
	logic [1:0]              q_s2;
	logic [30:0]             sv;
	logic [30:0]             cv;
	logic [1:0]              q_sin;
	logic [63:0]             trig_al;
	logic [30:0]             sv_al;
	logic [30:0]             cv_al;
	logic [1:0]              q_al;
	logic [31:0]             radius;
	logic [30:0]             cm;
	logic [30:0]             sm;
	logic                    cn;
	logic                    sn;
	logic [62:0]             pc_s1;
	logic [62:0]             ps_s1;
	logic                    cn_s1;
	logic                    sn_s1;
	logic [OUT_W-1:0]        cos_q;
	logic [OUT_W-1:0]        sin_q;
	logic [OUT_W-1:0]        cos_d;
	logic [OUT_W-1:0]        sin_d;

	// The pipeline moves unless a finished result waits for the receiver.
	assign adv      = !vld_q[TOTAL_LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], s_tvalid};
		end
	end

	assign u_first  = s_tdata[UNIFORM_BITS-1:0];
	assign u_second = s_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS];
	assign f        = u_second[FB-1:0];

	// Radius path.
	bmn_radius #(.UNIFORM_BITS(UNIFORM_BITS)) u_radius (
		.clk     (clk),
		.en      (adv),
		.u_first (u_first),
		.radius  (radius)
	);

	// Angle within the quadrant: two partial products of f times pi/2.
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s1 <= f * HALF_PI_Q30[15:0];
			pp_hi_s1 <= f * HALF_PI_Q30[30:16];
			q_s1     <= u_second[UNIFORM_BITS-1:UNIFORM_BITS-2];
		end
	end

	assign ang_sum = ((FB + 31)'(pp_hi_s1) << 16) + (FB + 31)'(pp_lo_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			phi_s2  <= ang_sum[FB+30:FB];
			cphi_s2 <= HALF_PI_Q30 - ang_sum[FB+30:FB];
			q_s2    <= q_s1;
		end
	end

	// Sine and cosine lanes.
	bmn_sin u_sin (
		.clk (clk),
		.en  (adv),
		.x   (phi_s2),
		.s   (sv)
	);

	bmn_sin u_cos (
		.clk (clk),
		.en  (adv),
		.x   (cphi_s2),
		.s   (cv)
	);

	bmn_delay #(.DEPTH(SIN_LAT), .WIDTH(2)) u_q_dly (
		.clk  (clk),
		.en   (adv),
		.din  (q_s2),
		.dout (q_sin)
	);

	// Hold the trig values until the radius catches up.
	bmn_delay #(.DEPTH(ALIGN_LAT), .WIDTH(64)) u_align (
		.clk  (clk),
		.en   (adv),
		.din  ({q_sin, cv, sv}),
		.dout (trig_al)
	);

	assign sv_al = trig_al[30:0];
	assign cv_al = trig_al[61:31];
	assign q_al  = trig_al[63:62];

	// Quadrant mapping of the magnitudes and signs.
	always_comb begin
		case (q_al)
			2'd0: begin cm = cv_al; cn = 1'b0; sm = sv_al; sn = 1'b0; end
			2'd1: begin cm = sv_al; cn = 1'b1; sm = cv_al; sn = 1'b0; end
			2'd2: begin cm = cv_al; cn = 1'b1; sm = sv_al; sn = 1'b1; end
			default: begin cm = sv_al; cn = 1'b0; sm = cv_al; sn = 1'b1; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s1 <= radius * cm;
			ps_s1 <= radius * sm;
			cn_s1 <= cn;
			sn_s1 <= sn;
		end
	end

	// Round half up in magnitude, saturate, then apply the sign.
	function automatic logic [OUT_W-1:0] round_sat(input logic [62:0] prod, input logic neg);
		logic [63:0] mag;
		mag = (64'(prod) + ROUND) >> SH;
		if (neg) begin
			if (mag > HALF) mag = HALF;
			return OUT_W'(64'd0 - mag);
		end
		if (mag > HALF - 64'd1) mag = HALF - 64'd1;
		return OUT_W'(mag);
	endfunction

	assign cos_d = round_sat(pc_s1, cn_s1);
	assign sin_d = round_sat(ps_s1, sn_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_q <= cos_d;
			sin_q <= sin_d;
		end
	end

	assign m_tdata = OUT_TW'({sin_q, cos_q});

	// A waiting result blocks new input.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while a result is stalled");

	// An item in the stage before the output register reaches it.
	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_q[TOTAL_LAT-2]) |=> m_tvalid)
		else $error("result lost before the output register");

	// No result appears without an item behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !vld_q[TOTAL_LAT-2]) |=> !m_tvalid)
		else $error("result appeared without an input item");

endmodule

// ----- design/bmn_delay.sv -----
// Delay line that keeps a word in step with the rest of the pipeline.
// Uses nothing from the package.
`timescale 1ns / 1ps
module bmn_delay #(
	parameter int DEPTH = 1,
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// Shift one place each time the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

// ----- design/bmn_log.sv -----
// Base-2 logarithm of one minus the first uniform sample, by normalization and
// one squaring per stage. Depends on bmn_pkg.
`timescale 1ns / 1ps
module bmn_log import bmn_pkg::*; #(
	parameter int UNIFORM_BITS = DEF_UNIFORM_BITS,
	localparam int PW = $clog2(UNIFORM_BITS + 1)
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [UNIFORM_BITS-1:0] u_first,
	output logic [PW+29:0]          lg
);

	localparam int XW = UNIFORM_BITS + 1;

	logic [XW-1:0]    x;
	logic [PW-1:0]    p;
	logic [XW+29:0]   wide;
	logic [30:0]      m_s  [31];
	logic [29:0]      fr_s [31];
	logic [PW-1:0]    p_s  [31];

	// The fraction is 2^B minus the sample; find its top bit and normalize.
	always_comb begin
		x = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, u_first};
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) p = PW'(i);
		end
		wide = {x, 30'd0} >> p;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= wide[30:0];
			fr_s[0] <= '0;
			p_s[0]  <= p;
		end
	end

	// Each stage squares the mantissa and takes one fraction bit.
	for (genvar i = 1; i <= 30; i++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] top;
		assign sq  = m_s[i-1] * m_s[i-1];
		assign top = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i]  <= top[31] ? top[31:1] : top[30:0];
				fr_s[i] <= fr_s[i-1] | (30'(top[31]) << (30 - i));
				p_s[i]  <= p_s[i-1];
			end
		end
	end

	assign lg = {p_s[30], fr_s[30]};

endmodule

// ----- design/bmn_radius.sv -----
// Radius sqrt(-2 ln(1 - u1)) in Q28: logarithm, scaling by 2 ln 2, and a
// restoring square root, one result bit per stage. Depends on bmn_pkg, bmn_log.
`timescale 1ns / 1ps
module bmn_radius import bmn_pkg::*; #(
	parameter int UNIFORM_BITS = DEF_UNIFORM_BITS
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [UNIFORM_BITS-1:0] u_first,
	output logic [31:0]             radius
);

	localparam int PW = $clog2(UNIFORM_BITS + 1);
	localparam int TW = PW + 30;
	localparam int HW = TW - 18;

	logic [TW-1:0]    lg;
	logic [TW-1:0]    t;
	logic [45:0]      pp_lo_s1;
	logic [HW+27:0]   pp_hi_s1;
	logic [63:0]      scaled;
	logic [63:0]      n_s   [33];
	logic [63:0]      res_s [33];

	bmn_log #(.UNIFORM_BITS(UNIFORM_BITS)) u_log (
		.clk     (clk),
		.en      (en),
		.u_first (u_first),
		.lg      (lg)
	);

	// Distance below the top of the range, split for two narrow products.
	assign t = TW'(UNIFORM_BITS) * TW'(Q30_ONE) - lg;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s1 <= t[17:0] * LN2_Q28;
			pp_hi_s1 <= t[TW-1:18] * LN2_Q28;
		end
	end

	// Join the partial products and scale into the square root's operand.
	assign scaled = (64'(pp_hi_s1) << 18) + 64'(pp_lo_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]   <= (scaled >> 25) << 24;
			res_s[0] <= '0;
		end
	end

	// One trial subtraction per stage, from the top bit pair down.
	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_s[k] >= trial) begin
					n_s[k+1]   <= n_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1]   <= n_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign radius = res_s[32][31:0];

endmodule

// ----- design/bmn_sin.sv -----
// Sine of an angle in [0, pi/2] in Q30 by a Taylor series to x^15 in Horner
// form, three stages per term. Depends on bmn_pkg.
`timescale 1ns / 1ps
module bmn_sin import bmn_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] x,
	output logic [30:0] s
);

	logic [61:0] xx;
	logic [62:0] fin;
	logic [30:0] acc_s [8];
	logic [30:0] x_s   [8];
	logic [31:0] x2_s  [8];
	logic [30:0] s_q;

	// Square of the angle.
	assign xx = x * x;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s[0]  <= xx[61:30];
			x_s[0]   <= x;
			acc_s[0] <= Q30_ONE;
		end
	end

	// One Horner term: multiply, divide by a constant through its reciprocal,
	// correct the quotient by one and subtract from one.
	for (genvar j = 0; j < 7; j++) begin : g_term
		localparam logic [7:0]  D  = horner_div(7 - j);
		localparam logic [30:0] RC = horner_recip(7 - j);
		logic [62:0] prod;
		logic [63:0] recip_prod;
		logic [32:0] rem;
		logic [31:0] quo;
		logic [32:0] v_a, v_b;
		logic [30:0] q0_b;
		logic [30:0] x_a, x_b;
		logic [31:0] x2_a, x2_b;

		assign prod       = x2_s[j] * acc_s[j];
		assign recip_prod = v_a * RC;
		assign rem        = v_b - 33'(q0_b) * 33'(D);
		assign quo        = (rem >= 33'(D)) ? 32'(q0_b) + 32'd1 : 32'(q0_b);

		always_ff @(posedge clk) begin
			if (en) begin
				v_a  <= prod[62:30];
				x_a  <= x_s[j];
				x2_a <= x2_s[j];
				v_b  <= v_a;
				q0_b <= recip_prod[63:33];
				x_b  <= x_a;
				x2_b <= x2_a;
				acc_s[j+1] <= (quo >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - quo);
				x_s[j+1]   <= x_b;
				x2_s[j+1]  <= x2_b;
			end
		end
	end

	// Last multiplication by the angle.
	assign fin = x_s[7] * acc_s[7];

	always_ff @(posedge clk) begin
		if (en) begin
			s_q <= fin[60:30];
		end
	end

	assign s = s_q;

endmodule
